/* rtl/core/mbr_pkg.sv */
// Package: shared types, constants and helpers for the Mandelbrot pixel block.
`default_nettype none
package mbr_pkg;
  localparam int ITER_STAGES = 255;
  localparam int FRAC_BITS   = 28;
  localparam int COLUMN_BITS = 13;
  localparam int ROW_BITS    = 12;
  localparam int CELL_COUNT  = ITER_STAGES - 1;

  localparam logic [7:0]  ITER_LIM_RST = 8'd255;
  localparam logic [31:0] RE_ORG_RST   = 32'hE000_0000;
  localparam logic [27:0] RE_STEP_RST  = 28'd104858;
  localparam logic [31:0] IM_ORG_RST   = 32'hF000_0000;
  localparam logic [27:0] IM_STEP_RST  = 28'd167772;

  localparam logic [64:0] ESCAPE_BOUND = 65'd4 << (2 * FRAC_BITS);

  typedef enum logic [7:0] {
    REG_ITER_LIM = 8'd0,
    REG_RE_ORG   = 8'd1,
    REG_RE_STEP  = 8'd2,
    REG_IM_ORG   = 8'd3,
    REG_IM_STEP  = 8'd4
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    logic               done;
    logic [7:0]         k;
    logic [7:0]         limit;
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic signed [31:0] cre;
    logic signed [31:0] cim;
  } iter_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (x > hi) return 32'sh7FFF_FFFF;
    if (x < lo) return 32'sh8000_0000;
    return x[31:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/mbr_in_if.sv */
// Interface: pixel input channel.
`default_nettype none
interface mbr_in_if import mbr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COLUMN_BITS-1:0] column;
  logic [ROW_BITS-1:0]    row;
  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface
`default_nettype wire

/* rtl/core/mbr_out_if.sv */
// Interface: color result channel.
`default_nettype none
interface mbr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

/* rtl/core/mbr_cfg_if.sv */
// Interface: configuration write channel.
`default_nettype none
interface mbr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/mbr_coord.sv */
// Coordinate stage: maps column and row to the point c.
`default_nettype none
module mbr_coord import mbr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_take,
  input  wire logic [COLUMN_BITS-1:0] column,
  input  wire logic [ROW_BITS-1:0]    row,
  input  wire logic [7:0]             iter_lim,
  input  wire logic signed [31:0]     re_org,
  input  wire logic [27:0]            re_step,
  input  wire logic signed [31:0]     im_org,
  input  wire logic [27:0]            im_step,
  output iter_t                       q
);
  logic                           m_valid_r;
  logic [COLUMN_BITS+27:0]        re_off_r;
  logic [ROW_BITS+27:0]           im_off_r;
  logic [7:0]                     limit_r;
  logic signed [31:0]             re_base_r;
  logic signed [31:0]             im_base_r;
  iter_t                          q_r;
  logic signed [65:0]             re_sum;
  logic signed [65:0]             im_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      q_r.valid <= 1'b0;
    end else if (en) begin
      m_valid_r <= in_take;
      q_r.valid <= m_valid_r;
    end
    if (en) begin
      re_off_r  <= column * re_step;
      im_off_r  <= row * im_step;
      limit_r   <= iter_lim;
      re_base_r <= re_org;
      im_base_r <= im_org;
      q_r.done  <= 1'b0;
      q_r.k     <= 8'd1;
      q_r.limit <= limit_r;
      q_r.u     <= '0;
      q_r.v     <= '0;
      q_r.cre   <= sat32(re_sum);
      q_r.cim   <= sat32(im_sum);
    end
  end

  always_comb begin
    re_sum = 66'(re_base_r) + $signed(66'(re_off_r));
    im_sum = 66'(im_base_r) + $signed(66'(im_off_r));
  end

  assign q = q_r;
endmodule
`default_nettype wire

/* rtl/core/mbr_cell.sv */
// Iteration cell: one step of z = z*z + c over two register stages.
`default_nettype none
module mbr_cell import mbr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire iter_t d,
  output iter_t      q
);
  iter_t              s_r;
  logic signed [63:0] u2_r;
  logic signed [63:0] v2_r;
  logic signed [63:0] uv_r;
  iter_t              q_r;
  iter_t              q_nxt;
  logic [64:0]        mag2;
  logic signed [65:0] diff;
  logic signed [65:0] nu_w;
  logic signed [65:0] nv_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.valid <= 1'b0;
      q_r.valid <= 1'b0;
    end else if (en) begin
      s_r.valid <= d.valid;
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      s_r.done  <= d.done;
      s_r.k     <= d.k;
      s_r.limit <= d.limit;
      s_r.u     <= d.u;
      s_r.v     <= d.v;
      s_r.cre   <= d.cre;
      s_r.cim   <= d.cim;
      u2_r      <= d.u * d.u;
      v2_r      <= d.v * d.v;
      uv_r      <= d.u * d.v;
      q_r.done  <= q_nxt.done;
      q_r.k     <= q_nxt.k;
      q_r.limit <= q_nxt.limit;
      q_r.u     <= q_nxt.u;
      q_r.v     <= q_nxt.v;
      q_r.cre   <= q_nxt.cre;
      q_r.cim   <= q_nxt.cim;
    end
  end

  always_comb begin
    mag2  = {1'b0, u2_r} + {1'b0, v2_r};
    diff  = 66'(u2_r) - 66'(v2_r);
    nu_w  = (diff >>> FRAC_BITS) + 66'(s_r.cre);
    nv_w  = (66'(uv_r) >>> (FRAC_BITS - 1)) + 66'(s_r.cim);
    q_nxt = s_r;
    if (!s_r.done && (s_r.k < s_r.limit) && (mag2 < ESCAPE_BOUND)) begin
      q_nxt.u = sat32(nu_w);
      q_nxt.v = sat32(nv_w);
      q_nxt.k = s_r.k + 8'd1;
    end else begin
      q_nxt.done = 1'b1;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

/* rtl/core/mbr_color.sv */
// Color stage: squares the final real part and forms the output item.
`default_nettype none
module mbr_color import mbr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  en,
  input  wire iter_t d,
  output logic       valid,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue
);
  logic               s_valid_r;
  logic [7:0]         k_r;
  logic signed [31:0] u_r;
  logic signed [63:0] u2_r;
  logic               valid_r;
  logic [7:0]         red_r;
  logic [7:0]         green_r;
  logic [7:0]         blue_r;
  logic [32:0]        mag;
  logic [7:0]         g;
  logic [7:0]         b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      valid_r   <= 1'b0;
    end else if (en) begin
      s_valid_r <= d.valid;
      valid_r   <= s_valid_r;
    end
    if (en) begin
      k_r     <= d.k;
      u_r     <= d.u;
      u2_r    <= d.u * d.u;
      red_r   <= k_r;
      green_r <= 8'd0 - g;
      blue_r  <= 8'd0 - b;
    end
  end

  always_comb begin
    mag = u_r[31] ? (33'd0 - 33'(u_r)) : 33'(u_r);
    g   = 8'(mag >> (FRAC_BITS + 1));
    b   = 8'(u2_r[63:0] >> (2 * FRAC_BITS + 1));
  end

  assign valid = valid_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;
endmodule
`default_nettype wire

/* rtl/core/mandelbrot_escape_time_pixel.sv */
// Top level: Mandelbrot escape-time pixel colorizer built as a chain of iteration cells.
// Usage:
//   in_if   : pixel items (column, row), accepted when valid and ready are high.
//   out_if  : color items (red, green, blue), one per input item, in order.
//   cfg_if  : register writes (index, data); always ready. Index 0 iteration
//             limit, 1 real origin, 2 real step, 3 imaginary origin,
//             4 imaginary step; others ignored.
//             Write only while no item is in flight.
// Throughput: one pixel per cycle while the receiver takes results.
// Pipeline: the coordinate stage, then the row of ITER_STAGES-1 cells, each doing
//   one iteration in two register stages (multiply, then add and escape test),
//   then the color stage. Escaped pixels ride through the remaining cells
//   unchanged.
// Reset: rst_n (synchronous, low) empties the pipeline and loads the default
//   view registers.
// Stall: while a result waits and out_if.ready is low, the whole chain holds
//   and in_if.ready is low; nothing is lost or repeated.
`default_nettype none
module mandelbrot_escape_time_pixel import mbr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mbr_in_if.sink    in_if,
  mbr_out_if.source out_if,
  mbr_cfg_if.sink   cfg_if
);
  logic [7:0]         iter_lim_r;
  logic signed [31:0] re_org_r;
  logic [27:0]        re_step_r;
  logic signed [31:0] im_org_r;
  logic [27:0]        im_step_r;
  logic               en;
  iter_t              chain [0:CELL_COUNT];

  assign en           = !out_if.valid || out_if.ready;
  assign in_if.ready  = en;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_lim_r <= ITER_LIM_RST;
      re_org_r   <= RE_ORG_RST;
      re_step_r  <= RE_STEP_RST;
      im_org_r   <= IM_ORG_RST;
      im_step_r  <= IM_STEP_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_ITER_LIM: iter_lim_r <= cfg_if.data[7:0];
        REG_RE_ORG:   re_org_r   <= cfg_if.data;
        REG_RE_STEP:  re_step_r  <= cfg_if.data[27:0];
        REG_IM_ORG:   im_org_r   <= cfg_if.data;
        REG_IM_STEP:  im_step_r  <= cfg_if.data[27:0];
        default: ;
      endcase
    end
  end

  mbr_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_take  (in_if.valid),
    .column   (in_if.column),
    .row      (in_if.row),
    .iter_lim (iter_lim_r),
    .re_org   (re_org_r),
    .re_step  (re_step_r),
    .im_org   (im_org_r),
    .im_step  (im_step_r),
    .q        (chain[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    mbr_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  mbr_color u_color (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d     (chain[CELL_COUNT]),
    .valid (out_if.valid),
    .red   (out_if.red),
    .green (out_if.green),
    .blue  (out_if.blue)
  );
endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench: random and directed pixel traffic, checked against a local predictor.
module tb;
  import mbr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  mbr_in_if  in_if ();
  mbr_out_if out_if ();
  mbr_cfg_if cfg_if ();

  mandelbrot_escape_time_pixel u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  typedef struct packed {
    logic [12:0] column;
    logic [11:0] row;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  localparam int LATENCY = 2 * (ITER_STAGES - 1) + 4;
  localparam int WATCHDOG = 20 * LATENCY;

  logic [7:0]         lim_reg;
  logic signed [31:0] re0_reg;
  logic [27:0]        rstep_reg;
  logic signed [31:0] im0_reg;
  logic [27:0]        istep_reg;

  pixel_t pixel_q[$];
  color_t color_q[$];
  int     errors = 0;
  int     pixels_sent = 0;
  int     colors_seen = 0;
  int     escaped_early = 0;
  int     idle_cycles = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] x);
    if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic color_t escape_color(input pixel_t p);
    logic signed [31:0] cre, cim, u, v, nu, nv;
    logic signed [65:0] u2, v2, uv;
    logic [31:0]        mag;
    logic [7:0]         lim, k, g, b;
    color_t             c;
    cre = clamp32(66'(re0_reg) + $signed(66'(p.column) * 66'(rstep_reg)));
    cim = clamp32(66'(im0_reg) + $signed(66'(p.row) * 66'(istep_reg)));
    u = '0;
    v = '0;
    u2 = '0;
    v2 = '0;
    lim = lim_reg;
    k = 8'd1;
    while (k < lim && (u2 + v2) < 66'sd4 <<< 56) begin
      uv = 66'(u) * 66'(v);
      nv = clamp32((uv >>> (FRAC_BITS - 1)) + 66'(cim));
      nu = clamp32(((u2 - v2) >>> FRAC_BITS) + 66'(cre));
      u = nu;
      v = nv;
      u2 = 66'(u) * 66'(u);
      v2 = 66'(v) * 66'(v);
      k++;
    end
    mag = u < 0 ? 32'(-66'(u)) : 32'(u);
    g = 8'((mag >> (FRAC_BITS + 1)) * 255);
    b = 8'(((u2 >> (2 * FRAC_BITS + 1)) & 66'hFF) * 255);
    c.red = k;
    c.green = g;
    c.blue = b;
    return c;
  endfunction

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_if.valid <= 1'b0;
    end else if (pixel_q.size() > 0) begin
      in_if.valid <= 1'b1;
      in_if.column <= pixel_q[0].column;
      in_if.row <= pixel_q[0].row;
      pixel_q.pop_front();
      in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3) * ($urandom_range(0, 1));
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      color_t c;
      c = escape_color('{column: in_if.column, row: in_if.row});
      if (c.red < lim_reg) escaped_early++;
      color_q.push_back(c);
      pixels_sent++;
    end
  end

  // monitor
  int out_stall = 0;
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (out_if.valid) out_stall <= $urandom_range(0, 3) * $urandom_range(0, 1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      colors_seen++;
      if (color_q.size() == 0) begin
        $display("%0t: unexpected color %h", $time, {out_if.red, out_if.green, out_if.blue});
        errors++;
      end else begin
        color_t e;
        e = color_q.pop_front();
        if (e.red !== out_if.red)
          $display("%0t: red exp %0d got %0d", $time, e.red, out_if.red);
        if (e.green !== out_if.green)
          $display("%0t: green exp %0d got %0d", $time, e.green, out_if.green);
        if (e.blue !== out_if.blue)
          $display("%0t: blue exp %0d got %0d", $time, e.blue, out_if.blue);
        if (e !== {out_if.red, out_if.green, out_if.blue}) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_ITER_LIM: lim_reg = data[7:0];
      REG_RE_ORG:   re0_reg = data;
      REG_RE_STEP:  rstep_reg = data[27:0];
      REG_IM_ORG:   im0_reg = data;
      REG_IM_STEP:  istep_reg = data[27:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    wait (pixel_q.size() == 0 && !in_if.valid && color_q.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic push_pixel(input int col, input int row);
    pixel_t p;
    p.column = 13'(col);
    p.row = 12'(row);
    pixel_q.push_back(p);
  endtask

  task automatic random_view(input int n, input logic [7:0] lim, input int wide);
    write_reg(REG_ITER_LIM, lim);
    write_reg(REG_RE_ORG, wide ? $urandom : 32'hE000_0000 + $urandom_range(0, 1 << 26));
    write_reg(REG_RE_STEP, wide ? $urandom : $urandom_range(0, 1 << 18));
    write_reg(REG_IM_ORG, wide ? $urandom : 32'hF000_0000 + $urandom_range(0, 1 << 26));
    write_reg(REG_IM_STEP, wide ? $urandom : $urandom_range(0, 1 << 18));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) push_pixel($urandom_range(0, 8191), $urandom_range(0, 4095));
      else push_pixel($urandom_range(0, 2047), $urandom_range(0, 1535));
    end
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.column = '0;
    in_if.row = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_ITER_LIM;
    cfg_if.data = '0;
    lim_reg = ITER_LIM_RST;
    re0_reg = RE_ORG_RST;
    rstep_reg = RE_STEP_RST;
    im0_reg = IM_ORG_RST;
    istep_reg = IM_STEP_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // reset view, corners and overflow of coordinates
    push_pixel(0, 0);
    push_pixel(8191, 4095);
    push_pixel(8191, 0);
    push_pixel(0, 4095);
    push_pixel(1500, 600);
    push_pixel(1200, 900);
    push_pixel(5461, 2730);
    push_pixel(2730, 1365);
    drain();
    // limits of zero and one: no iteration
    write_reg(REG_ITER_LIM, 8'd0);
    push_pixel(100, 100);
    push_pixel(8191, 4095);
    drain();
    write_reg(REG_ITER_LIM, 8'd1);
    push_pixel(0, 0);
    push_pixel(4000, 2000);
    drain();
    // saturating iterates with extreme starts and steps
    write_reg(REG_ITER_LIM, 8'd2);
    write_reg(REG_RE_ORG, 32'h7FFF_FFFF);
    write_reg(REG_RE_STEP, 28'hFFF_FFFF);
    write_reg(REG_IM_ORG, 32'h8000_0000);
    write_reg(REG_IM_STEP, 28'hFFF_FFFF);
    push_pixel(0, 0);
    push_pixel(1, 1);
    push_pixel(8191, 4095);
    push_pixel(0, 4095);
    drain();
    write_reg(REG_ITER_LIM, 8'd255);
    write_reg(REG_RE_ORG, 32'h8000_0000);
    write_reg(REG_RE_STEP, 28'd0);
    write_reg(REG_IM_ORG, 32'h7FFF_FFFF);
    write_reg(REG_IM_STEP, 28'd0);
    push_pixel(3, 5);
    push_pixel(8191, 4095);
    drain();
    random_view(300, 8'd255, 0);
    random_view(200, 8'($urandom_range(2, 60)), 0);
    random_view(150, 8'($urandom_range(0, 255)), 1);
    random_view(250, 8'($urandom_range(100, 255)), 0);
    $display("pixels %0d, colors %0d, escaped before limit %0d",
             pixels_sent, colors_seen, escaped_early);
    if (errors == 0 && color_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
